### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl, clocked on clk, quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define WMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence holds in the cycle after the trigger
`define WMF_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

### hw/rtl/wmf_pkg.sv
package wmf_pkg;

	localparam int RADIUS     = 4;
	localparam int MAX_COLS   = 1024;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 11;
	localparam int DIMX_W     = DIM_W + 1;
	localparam int SPAN       = 2 * RADIUS + 1;
	localparam int WIN        = SPAN * SPAN;
	localparam int LINE_DEPTH = 2 * RADIUS * MAX_COLS + 2 * RADIUS + 1;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int SUM_W      = ADDR_W + 1;
	localparam int CNT_W      = $clog2(WIN + 1);
	localparam int SPAN_W     = $clog2(SPAN + 1);
	localparam int BIT_W      = $clog2(PIX_W + 1);
	localparam int PCNT_W     = 2 * DIM_W;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic clear;
		logic push;
		logic start;
	} sel_ctrl_t;

	// circular address arithmetic, both operands below LINE_DEPTH
	function automatic logic [ADDR_W-1:0] mod_add(input logic [ADDR_W-1:0] a,
		input logic [ADDR_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= SUM_W'(LINE_DEPTH))
			s = s - SUM_W'(LINE_DEPTH);
		return s[ADDR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] mod_sub(input logic [ADDR_W-1:0] a,
		input logic [ADDR_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = {1'b0, a} - {1'b0, b};
		if (s[ADDR_W])
			s = s + SUM_W'(LINE_DEPTH);
		return s[ADDR_W-1:0];
	endfunction

endpackage

### hw/rtl/wmf_line_mem.sv
module wmf_line_mem (
	input  logic                        clk,
	input  logic                        we,
	input  logic [wmf_pkg::ADDR_W-1:0]  waddr,
	input  logic [wmf_pkg::PIX_W-1:0]   wdata,
	input  logic                        re,
	input  logic [wmf_pkg::ADDR_W-1:0]  raddr,
	output logic [wmf_pkg::PIX_W-1:0]   rdata
);

	logic [wmf_pkg::PIX_W-1:0] mem_q [wmf_pkg::LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/wmf_rank_sel.sv
`include "assert_macros.svh"

module wmf_rank_sel (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wmf_pkg::sel_ctrl_t         ctrl,
	input  logic [wmf_pkg::PIX_W-1:0]  push_data,
	output logic                       done,
	output logic [wmf_pkg::PIX_W-1:0]  result
);

	logic [wmf_pkg::PIX_W-1:0] win_q [wmf_pkg::WIN];
	logic [wmf_pkg::CNT_W-1:0] n_q;
	logic [wmf_pkg::CNT_W-1:0] t_q;
	logic [wmf_pkg::WIN-1:0]   cand_q;
	logic [wmf_pkg::BIT_W-1:0] bit_q;
	logic                      busy_q;
	logic                      done_q;
	logic [wmf_pkg::PIX_W-1:0] res_q;

	logic [wmf_pkg::WIN-1:0]   msb;
	logic [wmf_pkg::WIN-1:0]   zeros;
	logic [wmf_pkg::WIN-1:0]   therm;
	logic [wmf_pkg::CNT_W-1:0] z;

	always_comb begin
		for (int i = 0; i < wmf_pkg::WIN; i++) begin
			msb[i]   = win_q[i][wmf_pkg::PIX_W-1];
			therm[i] = (wmf_pkg::CNT_W'(i) < n_q);
		end
		zeros = cand_q & ~msb;
		z     = wmf_pkg::CNT_W'($countones(zeros));
	end

	// window values, shifted in on push and one bit plane up per select step
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			win_q[0] <= push_data;
			for (int i = 1; i < wmf_pkg::WIN; i++)
				win_q[i] <= win_q[i-1];
		end else if (busy_q) begin
			for (int i = 0; i < wmf_pkg::WIN; i++)
				win_q[i] <= win_q[i] << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.clear)
				n_q <= '0;
			else if (ctrl.push)
				n_q <= n_q + wmf_pkg::CNT_W'(1);
			if (ctrl.start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + wmf_pkg::BIT_W'(1);
				if (bit_q == wmf_pkg::BIT_W'(wmf_pkg::PIX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// rank counted from the smallest value
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			cand_q <= therm;
			t_q    <= n_q - (n_q >> 1) - wmf_pkg::CNT_W'(1);
		end else if (busy_q) begin
			if (t_q < z) begin
				res_q  <= {res_q[wmf_pkg::PIX_W-2:0], 1'b0};
				cand_q <= zeros;
			end else begin
				res_q  <= {res_q[wmf_pkg::PIX_W-2:0], 1'b1};
				t_q    <= t_q - z;
				cand_q <= cand_q & msb;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`WMF_ASSERT(a_count_bound, n_q <= wmf_pkg::CNT_W'(wmf_pkg::WIN), "window count overflow")
	`WMF_ASSERT(a_cand_live, !busy_q || (cand_q != '0) || (n_q == '0), "no candidate left")
	`WMF_ASSERT_NEXT(a_done_ends_run, done_q, !busy_q, "select still busy after done")

endmodule

### hw/rtl/windowed_median_filter.sv
// channel  | handshake                     | payload
// config   | cfg_we                        | cfg_index, cfg_data
// input    | in_valid / in_stall (driven)  | operation, pixel
// output   | out_valid / out_stall (taken) | median_value, end_of_frame
//
// an item that gives no result leaves the block idle and ready for the next item;
// one that gives a result holds in_stall until that result is loaded for output:
// w*h window reads (up to 81) from the single read port of the line store, then
// bit-serial selection; reset restores 1024 x 1024; the line store is not cleared
// a waiting result stalls the block only when the next result is ready

`include "assert_macros.svh"

module windowed_median_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wmf_pkg::DIM_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [wmf_pkg::PIX_W-1:0]          pixel,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [wmf_pkg::PIX_W-1:0]          median_value,
	output logic                               end_of_frame
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_BACK_COL = 3'd1;
	localparam logic [2:0] ST_BACK_ROW = 3'd2;
	localparam logic [2:0] ST_GATHER   = 3'd3;
	localparam logic [2:0] ST_FLUSH    = 3'd4;
	localparam logic [2:0] ST_START    = 3'd5;
	localparam logic [2:0] ST_SELECT   = 3'd6;
	localparam logic [2:0] ST_OUT      = 3'd7;

	logic [2:0]                    state_q;
	logic [wmf_pkg::DIM_W-1:0]     rows_q, cols_q, rows_eff, cols_eff;
	logic [wmf_pkg::DIM_W-1:0]     in_row_q, in_col_q, out_row_q, out_col_q;
	logic [wmf_pkg::PCNT_W-1:0]    pcnt_q, lag;
	logic [wmf_pkg::ADDR_W-1:0]    wr_addr_q, out_addr_q, cur_q, rowstart_q, cols_a;
	logic [wmf_pkg::SPAN_W-1:0]    dc_q, dr_q, w_q, h_q, gcol_q, grow_q;
	logic [wmf_pkg::SPAN_W-1:0]    dc, dr, rc, rr;
	logic                          eof_item_q, rd_valid_s1;
	logic                          out_valid_q, end_q;
	logic [wmf_pkg::PIX_W-1:0]     median_q;

	logic                          in_acc, px_ok, out_pos_ok, emit, emit_last, cfg_hit;
	logic                          mem_re, load_out;
	logic [wmf_pkg::PIX_W-1:0]     mem_rdata, sel_result;
	logic                          sel_done;
	wmf_pkg::sel_ctrl_t            sel_ctrl;

	always_comb begin
		rows_eff = (rows_q == '0) ? wmf_pkg::DIM_W'(1) : rows_q;
		if (cols_q == '0)
			cols_eff = wmf_pkg::DIM_W'(1);
		else if (32'(cols_q) > wmf_pkg::MAX_COLS)
			cols_eff = wmf_pkg::DIM_W'(wmf_pkg::MAX_COLS);
		else
			cols_eff = cols_q;
		cols_a = wmf_pkg::ADDR_W'(cols_eff);
		lag = wmf_pkg::PCNT_W'(cols_eff) * wmf_pkg::PCNT_W'(wmf_pkg::RADIUS)
			+ wmf_pkg::PCNT_W'(wmf_pkg::RADIUS);
	end

	// clipped window extent around the next output position
	always_comb begin
		dc = (out_col_q >= wmf_pkg::DIM_W'(wmf_pkg::RADIUS)) ?
			wmf_pkg::SPAN_W'(wmf_pkg::RADIUS) : wmf_pkg::SPAN_W'(out_col_q);
		dr = (out_row_q >= wmf_pkg::DIM_W'(wmf_pkg::RADIUS)) ?
			wmf_pkg::SPAN_W'(wmf_pkg::RADIUS) : wmf_pkg::SPAN_W'(out_row_q);
		rc = ({1'b0, out_col_q} + wmf_pkg::DIMX_W'(wmf_pkg::RADIUS) < {1'b0, cols_eff}) ?
			wmf_pkg::SPAN_W'(wmf_pkg::RADIUS) :
			wmf_pkg::SPAN_W'(cols_eff - wmf_pkg::DIM_W'(1) - out_col_q);
		rr = ({1'b0, out_row_q} + wmf_pkg::DIMX_W'(wmf_pkg::RADIUS) < {1'b0, rows_eff}) ?
			wmf_pkg::SPAN_W'(wmf_pkg::RADIUS) :
			wmf_pkg::SPAN_W'(rows_eff - wmf_pkg::DIM_W'(1) - out_row_q);
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign cfg_hit    = cfg_we && (cfg_index == wmf_pkg::REG_ROWS || cfg_index == wmf_pkg::REG_COLS);
	assign px_ok      = in_acc && (operation == wmf_pkg::OP_PIXEL)
		&& (in_row_q < rows_eff) && (in_col_q < cols_eff);
	assign out_pos_ok = (out_row_q < rows_eff) && (out_col_q < cols_eff);
	assign emit       = in_acc && out_pos_ok && (px_ok ? (pcnt_q >= lag) :
		((operation == wmf_pkg::OP_DRAIN) && (in_row_q >= rows_eff)));
	assign emit_last  = (out_row_q == rows_eff - wmf_pkg::DIM_W'(1))
		&& (out_col_q == cols_eff - wmf_pkg::DIM_W'(1));
	assign mem_re     = (state_q == ST_GATHER);
	assign load_out   = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	assign sel_ctrl.clear = emit;
	assign sel_ctrl.push  = rd_valid_s1;
	assign sel_ctrl.start = (state_q == ST_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_q      <= wmf_pkg::DIM_W'(1024);
			cols_q      <= wmf_pkg::DIM_W'(1024);
			in_row_q    <= '0;
			in_col_q    <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			pcnt_q      <= '0;
			wr_addr_q   <= '0;
			out_addr_q  <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= mem_re;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			if (cfg_hit) begin
				if (cfg_index == wmf_pkg::REG_ROWS)
					rows_q <= cfg_data;
				else
					cols_q <= cfg_data;
				in_row_q   <= '0;
				in_col_q   <= '0;
				out_row_q  <= '0;
				out_col_q  <= '0;
				pcnt_q     <= '0;
				wr_addr_q  <= '0;
				out_addr_q <= '0;
			end else begin
				if (px_ok) begin
					pcnt_q    <= pcnt_q + wmf_pkg::PCNT_W'(1);
					wr_addr_q <= wmf_pkg::mod_add(wr_addr_q, wmf_pkg::ADDR_W'(1));
					if (in_col_q + wmf_pkg::DIM_W'(1) >= cols_eff) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + wmf_pkg::DIM_W'(1);
					end else begin
						in_col_q <= in_col_q + wmf_pkg::DIM_W'(1);
					end
				end
				if (emit) begin
					out_addr_q <= wmf_pkg::mod_add(out_addr_q, wmf_pkg::ADDR_W'(1));
					if (out_col_q + wmf_pkg::DIM_W'(1) >= cols_eff) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + wmf_pkg::DIM_W'(1);
					end else begin
						out_col_q <= out_col_q + wmf_pkg::DIM_W'(1);
					end
					// last result of the frame: every position starts over
					if (emit_last) begin
						in_row_q   <= '0;
						in_col_q   <= '0;
						out_row_q  <= '0;
						out_col_q  <= '0;
						pcnt_q     <= '0;
						wr_addr_q  <= '0;
						out_addr_q <= '0;
					end
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (emit)
						state_q <= ST_BACK_COL;
				end
				ST_BACK_COL: begin
					state_q <= (dr_q == '0) ? ST_GATHER : ST_BACK_ROW;
				end
				ST_BACK_ROW: begin
					if (dr_q == wmf_pkg::SPAN_W'(1))
						state_q <= ST_GATHER;
				end
				ST_GATHER: begin
					if (gcol_q == w_q - wmf_pkg::SPAN_W'(1)
						&& grow_q == h_q - wmf_pkg::SPAN_W'(1))
						state_q <= ST_FLUSH;
				end
				ST_FLUSH:  state_q <= ST_START;
				ST_START:  state_q <= ST_SELECT;
				ST_SELECT: begin
					if (sel_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// window address walk: back to the top-left corner, then row by row
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (emit) begin
					cur_q      <= out_addr_q;
					dc_q       <= dc;
					dr_q       <= dr;
					w_q        <= dc + rc + wmf_pkg::SPAN_W'(1);
					h_q        <= dr + rr + wmf_pkg::SPAN_W'(1);
					eof_item_q <= emit_last;
				end
			end
			ST_BACK_COL: begin
				cur_q      <= wmf_pkg::mod_sub(cur_q, wmf_pkg::ADDR_W'(dc_q));
				rowstart_q <= wmf_pkg::mod_sub(cur_q, wmf_pkg::ADDR_W'(dc_q));
				gcol_q     <= '0;
				grow_q     <= '0;
			end
			ST_BACK_ROW: begin
				cur_q      <= wmf_pkg::mod_sub(cur_q, cols_a);
				rowstart_q <= wmf_pkg::mod_sub(cur_q, cols_a);
				dr_q       <= dr_q - wmf_pkg::SPAN_W'(1);
			end
			ST_GATHER: begin
				if (gcol_q == w_q - wmf_pkg::SPAN_W'(1)) begin
					gcol_q     <= '0;
					grow_q     <= grow_q + wmf_pkg::SPAN_W'(1);
					rowstart_q <= wmf_pkg::mod_add(rowstart_q, cols_a);
					cur_q      <= wmf_pkg::mod_add(rowstart_q, cols_a);
				end else begin
					gcol_q <= gcol_q + wmf_pkg::SPAN_W'(1);
					cur_q  <= wmf_pkg::mod_add(cur_q, wmf_pkg::ADDR_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			median_q <= sel_result;
			end_q    <= eof_item_q;
		end
	end

	wmf_line_mem u_line_mem (
		.clk   (clk),
		.we    (px_ok && !cfg_hit),
		.waddr (wr_addr_q),
		.wdata (pixel),
		.re    (mem_re),
		.raddr (cur_q),
		.rdata (mem_rdata)
	);

	wmf_rank_sel u_rank_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (sel_ctrl),
		.push_data (mem_rdata),
		.done      (sel_done),
		.result    (sel_result)
	);

	assign out_valid    = out_valid_q;
	assign median_value = median_q;
	assign end_of_frame = end_q;

	`WMF_ASSERT(a_done_in_select, !sel_done || state_q == ST_SELECT, "select done out of place")
	`WMF_ASSERT(a_addr_range, !mem_re || cur_q < wmf_pkg::ADDR_W'(wmf_pkg::LINE_DEPTH), "read address out of range")
	`WMF_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_q, "result not presented")

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 6000000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic [wmf_pkg::PIX_W-1:0] median;
		logic                      eof;
	} median_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [wmf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [wmf_pkg::DIM_W-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic                          operation;
	logic [wmf_pkg::PIX_W-1:0]     pixel;
	logic                          out_valid;
	logic                          out_stall;
	logic [wmf_pkg::PIX_W-1:0]     median_value;
	logic                          end_of_frame;

	median_t                   pending_medians[$];
	logic [wmf_pkg::PIX_W-1:0] frame_pix[int];
	logic [wmf_pkg::DIM_W-1:0] rows_reg, cols_reg;
	int               in_r, in_c, out_r, out_c;
	int               send_idle_pct, recv_idle_pct;
	int               n_errors, n_items, n_results, n_frames, n_cycles;

	windowed_median_filter u_top (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int rows_eff();
		return (rows_reg == 0) ? 1 : int'(rows_reg);
	endfunction

	function automatic int cols_eff();
		if (cols_reg == 0)
			return 1;
		return (cols_reg > wmf_pkg::MAX_COLS) ? wmf_pkg::MAX_COLS : int'(cols_reg);
	endfunction

	// median of the clipped window, largest-first order, index count/2
	function automatic logic [wmf_pkg::PIX_W-1:0] window_median(int r, int c);
		int vals[$];
		int rows, cols;
		rows = rows_eff();
		cols = cols_eff();
		for (int y = (r >= wmf_pkg::RADIUS ? r - wmf_pkg::RADIUS : 0);
			y <= r + wmf_pkg::RADIUS && y < rows; y++)
			for (int x = (c >= wmf_pkg::RADIUS ? c - wmf_pkg::RADIUS : 0);
				x <= c + wmf_pkg::RADIUS && x < cols; x++)
				vals.push_back(int'(frame_pix[y * cols + x]));
		vals.rsort();
		return wmf_pkg::PIX_W'(vals[vals.size() / 2]);
	endfunction

	function automatic void restart_frame();
		in_r = 0;
		in_c = 0;
		out_r = 0;
		out_c = 0;
	endfunction

	function automatic void emit_median();
		median_t m;
		int rows, cols;
		rows = rows_eff();
		cols = cols_eff();
		if (out_r >= rows || out_c >= cols)
			return;
		m.median = window_median(out_r, out_c);
		m.eof = (out_r == rows - 1) && (out_c == cols - 1);
		pending_medians.push_back(m);
		out_c++;
		if (out_c >= cols) begin
			out_c = 0;
			out_r++;
		end
		if (m.eof) begin
			n_frames++;
			restart_frame();
		end
	endfunction

	function automatic void predict_item(logic op, logic [wmf_pkg::PIX_W-1:0] pix);
		int rows, cols, pos;
		rows = rows_eff();
		cols = cols_eff();
		if (op == wmf_pkg::OP_PIXEL) begin
			if (in_r >= rows || in_c >= cols)
				return;
			pos = in_r * cols + in_c;
			frame_pix[pos] = pix;
			in_c++;
			if (in_c >= cols) begin
				in_c = 0;
				in_r++;
			end
			if (pos >= wmf_pkg::RADIUS * cols + wmf_pkg::RADIUS)
				emit_median();
		end else if (in_r >= rows) begin
			emit_median();
		end
	endfunction

	// entered and left at a rising edge
	task automatic send_item(logic op, logic [wmf_pkg::PIX_W-1:0] pix);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pixel <= pix;
		do @(negedge clk); while (in_stall);
		predict_item(op, pix);
		n_items++;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [wmf_pkg::CFG_IDX_W-1:0] idx,
		logic [wmf_pkg::DIM_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == wmf_pkg::REG_ROWS) begin
			rows_reg = data;
			restart_frame();
		end else if (idx == wmf_pkg::REG_COLS) begin
			cols_reg = data;
			restart_frame();
		end
		@(posedge clk);
	endtask

	task automatic set_frame(int rows, int cols);
		wait_drained();
		write_reg(wmf_pkg::REG_ROWS, wmf_pkg::DIM_W'(rows));
		write_reg(wmf_pkg::REG_COLS, wmf_pkg::DIM_W'(cols));
	endtask

	function automatic logic [wmf_pkg::PIX_W-1:0] rand_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return wmf_pkg::PIX_W'($urandom);
		endcase
	endfunction

	task automatic drain_frame();
		while (in_r >= rows_eff())
			send_item(wmf_pkg::OP_DRAIN, rand_pixel());
	endtask

	// one frame with random content; noise adds early drains and late pixels
	task automatic run_frame(int rows, int cols, bit noisy);
		set_frame(rows, cols);
		for (int k = 0; k < rows_eff() * cols_eff(); k++) begin
			if (noisy && $urandom_range(19) == 0)
				send_item(wmf_pkg::OP_DRAIN, rand_pixel());
			send_item(wmf_pkg::OP_PIXEL, rand_pixel());
		end
		if (noisy && $urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) send_item(wmf_pkg::OP_PIXEL, rand_pixel());
		drain_frame();
	endtask

	task automatic test_directed();
		// 1x1 image: the whole result comes from a drain; extreme pixel
		set_frame(1, 1);
		send_item(wmf_pkg::OP_DRAIN, 8'h00);
		send_item(wmf_pkg::OP_PIXEL, 8'hff);
		send_item(wmf_pkg::OP_PIXEL, 8'h00);
		drain_frame();
		// 3x3 of alternating extremes; early drain, a pause mid-frame, then a late pixel
		set_frame(3, 3);
		send_item(wmf_pkg::OP_DRAIN, 8'h5a);
		for (int k = 0; k < 9; k++) begin
			send_item(wmf_pkg::OP_PIXEL, k[0] ? 8'hff : 8'h00);
			if (k == 4) begin
				in_valid <= 1'b0;
				while (pending_medians.size() != 0)
					@(posedge clk);
			end
		end
		send_item(wmf_pkg::OP_PIXEL, 8'h11);
		drain_frame();
		// zero counts act as one, bad indexes do nothing
		wait_drained();
		write_reg(wmf_pkg::REG_ROWS, '0);
		write_reg(wmf_pkg::REG_COLS, '0);
		write_reg(wmf_pkg::CFG_IDX_W'(2), '1);
		write_reg(wmf_pkg::CFG_IDX_W'(3), '1);
		send_item(wmf_pkg::OP_PIXEL, 8'h80);
		drain_frame();
		// abandoned frame: a rewrite restarts without results
		set_frame(6, 6);
		repeat (5) send_item(wmf_pkg::OP_PIXEL, rand_pixel());
		wait_drained();
		write_reg(wmf_pkg::REG_COLS, 11'd6);
		repeat (36) send_item(wmf_pkg::OP_PIXEL, rand_pixel());
		drain_frame();
	endtask

	task automatic test_extreme_sizes();
		run_frame(40, 1, 1'b0);
		run_frame(1, 40, 1'b0);
	endtask

	task automatic test_random(int s_pct, int r_pct, int budget);
		int start;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = n_items;
		while (n_items - start < budget) begin
			if ($urandom_range(9) == 0) begin
				set_frame($urandom_range(1, 12), $urandom_range(1, 12));
				repeat ($urandom_range(1, 10)) send_item(wmf_pkg::OP_PIXEL, rand_pixel());
			end else if ($urandom_range(9) == 0) begin
				run_frame($urandom_range(10, 20), $urandom_range(10, 20), 1'b1);
			end else begin
				run_frame($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(1));
			end
		end
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(negedge clk) begin
		median_t m;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_medians.size() == 0) begin
				$error("unexpected transfer: median_value %0d end_of_frame %0d",
					median_value, end_of_frame);
				n_errors++;
			end else begin
				m = pending_medians.pop_front();
				if (median_value !== m.median) begin
					$error("median_value: expected %0d, got %0d", m.median, median_value);
					n_errors++;
				end
				if (end_of_frame !== m.eof) begin
					$error("end_of_frame: expected %0d, got %0d", m.eof, end_of_frame);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = wmf_pkg::OP_PIXEL;
		pixel = '0;
		out_stall = 1'b0;
		n_cycles = 0;
		n_errors = 0;
		n_items = 0;
		n_results = 0;
		n_frames = 0;
		send_idle_pct = 19;
		recv_idle_pct = 53;
		rows_reg = 11'd1024;
		cols_reg = 11'd1024;
		restart_frame();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(19, 53, 260);
		test_random(53, 19, 260);
		test_random(0, 0, 260);
		test_extreme_sizes();
		wait_drained();
		$display("covered %0d input transfers, %0d medians over %0d frames",
			n_items, n_results, n_frames);
		$display("frames from 1x1 up to 20x20 and 40-long rows and columns, with drains and restarts");
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
